// File: sv/yfrs_pkg.sv
// Shared types and constants for the youngest-first revocation select block.
package yfrs_pkg;

	// Field widths.
	localparam int FUNC_W = 2;
	localparam int SEV_W  = 17;
	localparam int FRAC_W = 16;
	localparam int REV_W  = 6;
	localparam int AGE_W  = 32;
	localparam int ID_W   = 16;

	// The product of a revocable count and a severity, and the raw kill count.
	localparam int PROD_W = REV_W + SEV_W;
	localparam int K_W    = PROD_W - FRAC_W;

	// Revocable count saturates here.
	localparam logic [REV_W-1:0] REV_SAT = '1;

	// Added before the shift so that the kill count rounds up.
	localparam logic [PROD_W-1:0] CEIL_ADD = PROD_W'((1 << FRAC_W) - 1);

	// Default table depth.
	localparam int MAX_EXEC_DEF = 32;

	// Item function codes.
	localparam logic [FUNC_W-1:0] FUNC_CONT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EXEC   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DECIDE = 2'd2;

	// Register port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_BASE_SEV = 1'b0;

	// One stored executor.
	typedef struct packed {
		logic [AGE_W-1:0] age;
		logic [ID_W-1:0]  id;
	} entry_t;

	localparam int ENTRY_W = AGE_W + ID_W;

	// Round totals handed to the kill count unit.
	typedef struct packed {
		logic [REV_W-1:0] revocable_count;
		logic [SEV_W-1:0] max_severity;
		logic [SEV_W-1:0] base_severity;
	} kcalc_req_t;

endpackage

// File: sv/yfrs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module yfrs_ram #(
	parameter int W  = 8,
	parameter int D  = 32,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/yfrs_kcalc.sv
// Kill count unit: ceil(revocable count times severity) clamped to the stored count.
module yfrs_kcalc
	import yfrs_pkg::*;
#(
	parameter int CW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kcalc_req_t    req,
	input  logic [CW-1:0] stored_count,
	output logic          done,
	output logic [CW-1:0] k
);

	localparam int CMP_W = (K_W > CW) ? K_W : CW;

	logic              valid_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              valid_s2;
	logic [CW-1:0]     k_s2;
	logic [SEV_W-1:0]  sev;
	logic [PROD_W-1:0] rounded;
	logic [CMP_W-1:0]  k_raw;
	logic [CMP_W-1:0]  k_lim;

	// Effective severity is the larger of the running maximum and the floor.
	assign sev = (req.max_severity > req.base_severity) ? req.max_severity :
		req.base_severity;

	// Round up and clamp; the sum cannot overflow for these operand widths.
	assign rounded = prod_s1 + CEIL_ADD;
	assign k_raw   = CMP_W'(rounded[PROD_W-1:FRAC_W]);
	assign k_lim   = CMP_W'(stored_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// Multiply stage.
	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PROD_W'(req.revocable_count) * PROD_W'(sev);
		end
	end

	// Round and clamp stage.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			k_s2 <= (k_raw > k_lim) ? stored_count : CW'(k_raw);
		end
	end

	assign done = valid_s2;
	assign k    = k_s2;

endmodule

// File: sv/youngest_first_revocation_select.sv
// Top level of the youngest-first revocation select block.
//
// A round is built from contention items (func 0), executor items (func 1) and
// closed by a decide item (func 2). Revocable executors with a valid age are
// kept in one RAM sorted by ascending age, ties in arrival order; the table
// holds MAX_EXECUTORS entries and drops its oldest entry when full. An executor
// item that is stored is written straight into an empty table; otherwise the
// insertion moves each older entry up a slot, walking the RAM one entry per
// cycle through its single read port. A full table first compares the new
// entry with its oldest entry, and a new entry that is not younger than that
// one is dropped. A decide item first works out the kill count in the multiply
// and the round and clamp stages of the kill count unit and then emits the
// ids, each a RAM read followed by a load of the output register; the read
// waits while the output register still holds an id that is not taken.
// Contention items, executor items that are not stored and unused function
// codes are done in the cycle in which they are taken. Results wait in an
// output register, and the next item is taken while the last id of a decide
// waits there.
module youngest_first_revocation_select
	import yfrs_pkg::*;
#(
	parameter int MAX_EXECUTORS = MAX_EXEC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Register port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// Input items.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [FUNC_W-1:0]  func,
	input  logic               severity_valid,
	input  logic [SEV_W-1:0]   contention_severity,
	input  logic               executor_revocable,
	input  logic               age_valid,
	input  logic [AGE_W-1:0]   executor_age,
	input  logic [ID_W-1:0]    executor_id,
	// Result items.
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ID_W-1:0]    kill_id,
	output logic               last
);

	localparam int AW = (MAX_EXECUTORS > 1) ? $clog2(MAX_EXECUTORS) : 1;
	localparam int CW = $clog2(MAX_EXECUTORS + 1);

	localparam logic [CW-1:0] CNT_FULL = CW'(MAX_EXECUTORS);
	localparam logic [AW-1:0] TOP_IDX  = AW'(MAX_EXECUTORS - 1);

	// Controller states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_INS  = 3'd2;
	localparam logic [2:0] ST_PUT  = 3'd3;
	localparam logic [2:0] ST_CALC = 3'd4;
	localparam logic [2:0] ST_RD   = 3'd5;
	localparam logic [2:0] ST_LD   = 3'd6;

	logic [2:0]       state_q;
	logic [SEV_W-1:0] base_q;
	logic [SEV_W-1:0] max_sev_q;
	logic [REV_W-1:0] rev_cnt_q;
	logic [CW-1:0]    stored_q;
	logic [AGE_W-1:0] new_age_q;
	logic [ID_W-1:0]  new_id_q;
	logic [AW-1:0]    idx_q;
	logic [CW-1:0]    k_q;
	logic [CW-1:0]    emit_q;
	logic             out_valid_q;
	logic [ID_W-1:0]  kill_id_q;
	logic             last_q;

	logic             in_fire;
	logic             out_fire;
	logic             cfg_wr;
	logic             store_item;
	logic             slot_free;
	logic             older;
	logic             emit_last;
	entry_t           rd_entry;
	entry_t           wr_entry;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic             k_start;
	logic             k_done;
	logic [CW-1:0]    k_val;
	kcalc_req_t       k_req;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign store_item = in_fire && (func == FUNC_EXEC) && executor_revocable && age_valid;

	assign rd_entry  = entry_t'(ram_rdata);
	assign older     = rd_entry.age > new_age_q;
	assign emit_last = (emit_q + CW'(1)) == k_q;

	// Register port: writes complete in the access phase, reads are immediate.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_BASE_SEV) ? PDATA_W'(base_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr && (paddr[2] == REG_BASE_SEV)) begin
			base_q <= pwdata[SEV_W-1:0];
		end
	end

	// Entry table.
	yfrs_ram #(
		.W (ENTRY_W),
		.D (MAX_EXECUTORS),
		.AW(AW)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Kill count unit.
	assign k_start = in_fire && (func == FUNC_DECIDE);
	assign k_req   = '{revocable_count: rev_cnt_q, max_severity: max_sev_q,
		base_severity: base_q};

	yfrs_kcalc #(
		.CW(CW)
	) u_kcalc (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (k_start),
		.req         (k_req),
		.stored_count(stored_q),
		.done        (k_done),
		.k           (k_val)
	);

	// Table access: the insertion walks down from the top, moving each older
	// entry up one slot, until it finds the slot for the new entry.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		wr_entry  = '{age: new_age_q, id: new_id_q};
		ram_re    = 1'b0;
		ram_raddr = idx_q - AW'(1);
		unique case (state_q)
			ST_IDLE: begin
				if (store_item) begin
					if (stored_q == '0) begin
						ram_we    = 1'b1;
						ram_waddr = '0;
						wr_entry  = '{age: executor_age, id: executor_id};
					end else if (stored_q < CNT_FULL) begin
						ram_re    = 1'b1;
						ram_raddr = stored_q[AW-1:0] - AW'(1);
					end else begin
						ram_re    = 1'b1;
						ram_raddr = TOP_IDX;
					end
				end
			end
			ST_CHK: begin
				if (older) begin
					if (idx_q == '0) begin
						ram_we = 1'b1;
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			ST_INS: begin
				ram_we = 1'b1;
				if (older) begin
					wr_entry = rd_entry;
					if (idx_q != AW'(1)) begin
						ram_re    = 1'b1;
						ram_raddr = idx_q - AW'(2);
					end
				end
			end
			ST_PUT: begin
				ram_we = 1'b1;
			end
			ST_RD: begin
				if (slot_free) begin
					ram_re    = 1'b1;
					ram_raddr = emit_q[AW-1:0];
				end
			end
			ST_CALC, ST_LD: begin
			end
			default: begin
			end
		endcase
	end

	// Controller and round state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			max_sev_q <= '0;
			rev_cnt_q <= '0;
			stored_q  <= '0;
			idx_q     <= '0;
			k_q       <= '0;
			emit_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (func)
							FUNC_CONT: begin
								if (severity_valid && (contention_severity > max_sev_q)) begin
									max_sev_q <= contention_severity;
								end
							end
							FUNC_EXEC: begin
								if (executor_revocable && (rev_cnt_q != REV_SAT)) begin
									rev_cnt_q <= rev_cnt_q + REV_W'(1);
								end
								if (store_item) begin
									if (stored_q == '0) begin
										stored_q <= CW'(1);
									end else if (stored_q < CNT_FULL) begin
										idx_q    <= stored_q[AW-1:0];
										stored_q <= stored_q + CW'(1);
										state_q  <= ST_INS;
									end else begin
										idx_q   <= TOP_IDX;
										state_q <= ST_CHK;
									end
								end
							end
							FUNC_DECIDE: begin
								state_q <= ST_CALC;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHK: begin
					// A full table keeps its entries unless the new one is younger
					// than the last.
					if (!older || (idx_q == '0)) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					if (older) begin
						idx_q <= idx_q - AW'(1);
						if (idx_q == AW'(1)) begin
							state_q <= ST_PUT;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PUT: begin
					state_q <= ST_IDLE;
				end
				ST_CALC: begin
					if (k_done) begin
						max_sev_q <= '0;
						rev_cnt_q <= '0;
						stored_q  <= '0;
						k_q       <= k_val;
						emit_q    <= '0;
						state_q   <= (k_val == '0) ? ST_IDLE : ST_RD;
					end
				end
				ST_RD: begin
					if (slot_free) begin
						state_q <= ST_LD;
					end
				end
				ST_LD: begin
					emit_q  <= emit_q + CW'(1);
					state_q <= emit_last ? ST_IDLE : ST_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch the new entry while the insertion walks the table.
	always_ff @(posedge clk) begin
		if (store_item) begin
			new_age_q <= executor_age;
			new_id_q  <= executor_id;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_LD) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LD) begin
			kill_id_q <= rd_entry.id;
			last_q    <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign kill_id   = kill_id_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	// The table never holds more entries than it has slots.
	assert property (@(posedge clk) disable iff (!arst_n) stored_q <= CNT_FULL)
		else $error("stored count exceeds table depth");

	// A move during insertion never reads the slot it writes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("table read and write hit the same entry");

	// An id is loaded only into an empty output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD) |-> !out_valid_q)
		else $error("output register overwritten");

	// Emission never runs past the kill count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_LD) |-> (emit_q < k_q))
		else $error("emission index beyond kill count");

	// Items are taken only while the table is not being walked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS || state_q == ST_CHK || state_q == ST_PUT) |-> !in_ready)
		else $error("input taken during insertion");
`endif

endmodule
